FILE: rtl/atce_pkg.sv
// ----------------------------------------------------------------------------
// atce_pkg: shared types and constants for the ANSI text console engine
// Screen geometry, parser, command and executor types, and the ANSI-to-VGA color table.
// ----------------------------------------------------------------------------
package atce_pkg;

	localparam int Columns = 80;
	localparam int Rows = 25;
	localparam int CellCount = Columns * Rows;
	localparam int AddrW = 11;
	localparam int ColW = 7;
	localparam int RowW = 5;
	localparam int MaxParamChars = 3;
	localparam int TabSpaces = 4;
	localparam int QueueDepth = 2;

	localparam logic [7:0] ResetAttribute = 8'h07;
	localparam logic [7:0] ChEsc = 8'h1B;
	localparam logic [7:0] ChLf = 8'h0A;
	localparam logic [7:0] ChBs = 8'h08;
	localparam logic [7:0] ChTab = 8'h09;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChBracket = 8'h5B;
	localparam logic [7:0] ChH = 8'h48;
	localparam logic [7:0] ChJ = 8'h4A;
	localparam logic [7:0] ChM = 8'h6D;

	typedef enum logic [1:0] {
		PH_NORMAL,
		PH_ESCAPE,
		PH_CONTROL
	} phase_t;

	// Commands passed from the parser to the executor.
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_READ,
		CMD_PRINT,
		CMD_NEWLINE,
		CMD_BACKSPACE,
		CMD_HOME,
		CMD_CLEAR,
		CMD_COLOR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic esc_first;
		logic [3:0] repeat_cnt;
		logic [7:0] ch;
		logic [9:0] code;
		logic [AddrW-1:0] addr;
	} cmd_t;

	typedef enum logic [2:0] {
		EX_IDLE,
		EX_WORK,
		EX_SCROLL_RD,
		EX_SCROLL_WR,
		EX_FILL,
		EX_READ,
		EX_DONE
	} ex_state_t;

	function automatic logic [3:0] color_map(input logic [2:0] idx, input logic bright);
		logic [3:0] v;
		unique case (idx)
			3'd0: v = 4'h0;
			3'd1: v = 4'h4;
			3'd2: v = 4'h2;
			3'd3: v = 4'h6;
			3'd4: v = 4'h1;
			3'd5: v = 4'h5;
			3'd6: v = 4'h3;
			default: v = 4'h7;
		endcase
		return {bright, v[2:0]};
	endfunction

endpackage

FILE: rtl/atce_front.sv
// ----------------------------------------------------------------------------
// atce_front: request parser
// Accepts requests, runs the escape-sequence parser and emits commands.
// ----------------------------------------------------------------------------
module atce_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic req_type,
	input logic [7:0] char_byte,
	input logic [atce_pkg::AddrW-1:0] read_address,
	output logic cmd_valid,
	input logic cmd_stall,
	output atce_pkg::cmd_t cmd
);

	atce_pkg::phase_t phase_q, phase_d;
	logic [1:0] pcount_q, pcount_d;
	logic [9:0] pvalue_q, pvalue_d;
	logic ended_q, ended_d;
	logic is_digit;
	logic [13:0] prod;

	assign in_stall = cmd_stall;
	assign is_digit = (char_byte >= 8'h30) && (char_byte <= 8'h39);
	assign prod = pvalue_q * 4'd10 + {6'd0, char_byte[3:0]};

	always_comb begin
		phase_d = phase_q;
		pcount_d = pcount_q;
		pvalue_d = pvalue_q;
		ended_d = ended_q;
		cmd = '0;
		cmd.kind = atce_pkg::CMD_NONE;
		cmd.addr = read_address;
		cmd.ch = char_byte;
		cmd.code = pvalue_q;
		cmd.repeat_cnt = 4'd1;
		if (req_type) begin
			cmd.kind = atce_pkg::CMD_READ;
		end else begin
			unique case (phase_q)
				atce_pkg::PH_CONTROL: begin
					if (char_byte == atce_pkg::ChH && pcount_q == 2'd0) begin
						cmd.kind = atce_pkg::CMD_HOME;
						phase_d = atce_pkg::PH_NORMAL;
					end else if (char_byte == atce_pkg::ChJ && pcount_q == 2'd1 && !ended_q
							&& pvalue_q == 10'd2) begin
						cmd.kind = atce_pkg::CMD_CLEAR;
						phase_d = atce_pkg::PH_NORMAL;
					end else if (char_byte == atce_pkg::ChM) begin
						cmd.kind = atce_pkg::CMD_COLOR;
						phase_d = atce_pkg::PH_NORMAL;
					end else if (pcount_q < 2'(atce_pkg::MaxParamChars)) begin
						pcount_d = pcount_q + 2'd1;
						if (!ended_q && is_digit) pvalue_d = prod[9:0];
						else ended_d = 1'b1;
					end
				end
				default: begin
					if (phase_q == atce_pkg::PH_ESCAPE && char_byte == atce_pkg::ChBracket) begin
						phase_d = atce_pkg::PH_CONTROL;
						pcount_d = '0;
						pvalue_d = '0;
						ended_d = 1'b0;
					end else begin
						cmd.esc_first = (phase_q == atce_pkg::PH_ESCAPE);
						if (char_byte == atce_pkg::ChEsc) begin
							phase_d = atce_pkg::PH_ESCAPE;
						end else begin
							phase_d = atce_pkg::PH_NORMAL;
							if (char_byte == atce_pkg::ChLf) cmd.kind = atce_pkg::CMD_NEWLINE;
							else if (char_byte == atce_pkg::ChBs)
								cmd.kind = atce_pkg::CMD_BACKSPACE;
							else if (char_byte == atce_pkg::ChTab) begin
								cmd.kind = atce_pkg::CMD_PRINT;
								cmd.ch = atce_pkg::ChSpace;
								cmd.repeat_cnt = 4'(atce_pkg::TabSpaces);
							end else cmd.kind = atce_pkg::CMD_PRINT;
						end
					end
				end
			endcase
		end
	end

	// Every accepted request yields exactly one command, even if it does no work.
	assign cmd_valid = in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= atce_pkg::PH_NORMAL;
			pcount_q <= '0;
			pvalue_q <= '0;
			ended_q <= 1'b0;
		end else if (in_valid && !in_stall && !req_type) begin
			phase_q <= phase_d;
			pcount_q <= pcount_d;
			pvalue_q <= pvalue_d;
			ended_q <= ended_d;
		end
	end

endmodule

FILE: rtl/atce_queue.sv
// ----------------------------------------------------------------------------
// atce_queue: command queue
// Short queue that decouples the parser from the executor.
// ----------------------------------------------------------------------------
module atce_queue (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_stall,
	input atce_pkg::cmd_t wr_data,
	output logic rd_valid,
	input logic rd_take,
	output atce_pkg::cmd_t rd_data
);

	atce_pkg::cmd_t mem_q [atce_pkg::QueueDepth];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign wr_stall = (cnt_q == 2'(atce_pkg::QueueDepth));
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rp_q];
	assign push = wr_valid && !wr_stall;
	assign pop = rd_take && rd_valid;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(atce_pkg::QueueDepth))
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) (pop && !push) |=> cnt_q == $past(cnt_q) - 2'd1)
		else $error("queue pop miscount");
	assert property (@(posedge clk) disable iff (!arst_n) (push && !pop) |=> rd_valid)
		else $error("queue lost an entry");

endmodule

FILE: rtl/atce_back.sv
// ----------------------------------------------------------------------------
// atce_back: command executor
// Owns the cell store, cursor and attribute; runs prints, scrolls and clears.
// ----------------------------------------------------------------------------
module atce_back (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [7:0] cfg_data,
	input logic cmd_valid,
	output logic cmd_take,
	input atce_pkg::cmd_t cmd,
	output logic out_valid,
	input logic out_stall,
	output logic [15:0] cell_value,
	output logic [atce_pkg::ColW-1:0] cursor_column,
	output logic [atce_pkg::RowW-1:0] cursor_row,
	output logic [7:0] text_attribute
);

	localparam int Last = atce_pkg::CellCount - 1;
	// The scroll pointer runs one row past the store, so it needs one more bit.
	localparam int PtrW = atce_pkg::AddrW + 1;

	logic [15:0] mem [atce_pkg::CellCount];
	logic [15:0] rdata_q;
	logic [atce_pkg::AddrW-1:0] raddr;
	logic re;
	logic [atce_pkg::AddrW-1:0] waddr;
	logic [15:0] wdata;
	logic we;

	atce_pkg::ex_state_t state_q, state_d;
	atce_pkg::cmd_t cur_q;
	logic [atce_pkg::ColW-1:0] col_q, col_d;
	logic [atce_pkg::RowW-1:0] row_q, row_d;
	logic [7:0] attr_q, attr_d, dflt_q;
	logic [3:0] rep_q, rep_d;
	logic esc_q, esc_d;
	logic [PtrW-1:0] ptr_q, ptr_d;
	logic bound_q, bound_d;
	logic [15:0] cell_q, cell_d;
	logic cur_load;
	logic init_q;
	logic [atce_pkg::AddrW-1:0] cidx;
	logic [7:0] glyph;
	logic [3:0] nib;
	logic [9:0] code;
	logic [9:0] cbase, coff;

	assign cfg_ready = 1'b1;
	assign cidx = atce_pkg::AddrW'(row_q * atce_pkg::Columns) + atce_pkg::AddrW'(col_q);
	assign glyph = esc_q ? atce_pkg::ChEsc : cur_q.ch;
	assign code = cur_q.code;
	// Offset of the code within its color range selects the table entry.
	assign cbase = (code >= 10'd100) ? 10'd100 : (code >= 10'd90) ? 10'd90
		: (code >= 10'd40) ? 10'd40 : 10'd30;
	assign coff = code - cbase;
	assign nib = atce_pkg::color_map(coff[2:0], code >= 10'd90);

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	always_comb begin
		state_d = state_q;
		col_d = col_q;
		row_d = row_q;
		attr_d = attr_q;
		rep_d = rep_q;
		esc_d = esc_q;
		ptr_d = ptr_q;
		bound_d = bound_q;
		cell_d = cell_q;
		cur_load = 1'b0;
		cmd_take = 1'b0;
		we = 1'b0;
		waddr = cidx;
		wdata = {attr_q, 8'h00};
		re = 1'b0;
		raddr = ptr_q[atce_pkg::AddrW-1:0];
		out_valid = 1'b0;
		unique case (state_q)
			atce_pkg::EX_IDLE: begin
				if (init_q) begin
					// Post-reset clearing pass.
					state_d = atce_pkg::EX_FILL;
					ptr_d = '0;
				end else if (cmd_valid) begin
					cmd_take = 1'b1;
					cur_load = 1'b1;
					rep_d = cmd.repeat_cnt;
					esc_d = cmd.esc_first;
					cell_d = '0;
					state_d = atce_pkg::EX_WORK;
				end
			end
			atce_pkg::EX_WORK: begin
				if (esc_q || cur_q.kind == atce_pkg::CMD_PRINT) begin
					we = 1'b1;
					wdata = {attr_q, glyph};
					if (esc_q) esc_d = 1'b0;
					else rep_d = rep_q - 4'd1;
					if (col_q == atce_pkg::ColW'(atce_pkg::Columns - 1)) begin
						col_d = '0;
						if (row_q == atce_pkg::RowW'(atce_pkg::Rows - 1)) begin
							state_d = atce_pkg::EX_SCROLL_RD;
							ptr_d = PtrW'(atce_pkg::Columns);
						end else row_d = row_q + 1'b1;
					end else col_d = col_q + 1'b1;
					if (!esc_q && rep_q == 4'd1 && state_d == atce_pkg::EX_WORK)
						state_d = atce_pkg::EX_DONE;
				end else begin
					state_d = atce_pkg::EX_DONE;
					unique case (cur_q.kind)
						atce_pkg::CMD_READ: begin
							re = 1'b1;
							raddr = cur_q.addr;
							bound_d = cur_q.addr < atce_pkg::AddrW'(atce_pkg::CellCount);
							state_d = atce_pkg::EX_READ;
						end
						atce_pkg::CMD_NEWLINE: begin
							col_d = '0;
							rep_d = '0;
							if (row_q == atce_pkg::RowW'(atce_pkg::Rows - 1)) begin
								state_d = atce_pkg::EX_SCROLL_RD;
								ptr_d = PtrW'(atce_pkg::Columns);
							end else row_d = row_q + 1'b1;
						end
						atce_pkg::CMD_BACKSPACE: begin
							we = 1'b1;
							if (col_q == '0) begin
								if (row_q != '0) begin
									row_d = row_q - 1'b1;
									col_d = atce_pkg::ColW'(atce_pkg::Columns - 1);
									waddr = cidx - 1'b1;
								end
							end else begin
								col_d = col_q - 1'b1;
								waddr = cidx - 1'b1;
							end
						end
						atce_pkg::CMD_HOME: begin
							col_d = '0;
							row_d = '0;
						end
						atce_pkg::CMD_CLEAR: begin
							state_d = atce_pkg::EX_FILL;
							ptr_d = '0;
						end
						atce_pkg::CMD_COLOR: begin
							if (code == 10'd0) attr_d = dflt_q;
							else if ((code >= 10'd30 && code <= 10'd37)
									|| (code >= 10'd90 && code <= 10'd97))
								attr_d = {attr_q[7:4], nib};
							else if ((code >= 10'd40 && code <= 10'd47)
									|| (code >= 10'd100 && code <= 10'd107))
								attr_d = {nib, attr_q[3:0]};
						end
						default: ;
					endcase
				end
			end
			atce_pkg::EX_SCROLL_RD: begin
				re = 1'b1;
				raddr = ptr_q[atce_pkg::AddrW-1:0];
				state_d = atce_pkg::EX_SCROLL_WR;
			end
			atce_pkg::EX_SCROLL_WR: begin
				// Copy cell ptr to ptr-Columns, then blank the bottom row.
				// A pending count left over means the command still has work after the scroll.
				we = 1'b1;
				waddr = atce_pkg::AddrW'(ptr_q - PtrW'(atce_pkg::Columns));
				if (ptr_q >= PtrW'(atce_pkg::CellCount)) begin
					wdata = {attr_q, 8'h00};
				end else begin
					wdata = rdata_q;
				end
				ptr_d = ptr_q + 1'b1;
				if (ptr_q == PtrW'(atce_pkg::CellCount + atce_pkg::Columns - 1)) begin
					state_d = (rep_q != '0) ? atce_pkg::EX_WORK : atce_pkg::EX_DONE;
				end else if (ptr_q + 1'b1 < PtrW'(atce_pkg::CellCount)) begin
					state_d = atce_pkg::EX_SCROLL_RD;
				end
			end
			atce_pkg::EX_FILL: begin
				we = 1'b1;
				waddr = ptr_q[atce_pkg::AddrW-1:0];
				wdata = init_q ? 16'h0000 : {attr_q, 8'h00};
				ptr_d = ptr_q + 1'b1;
				if (ptr_q == PtrW'(Last))
					state_d = init_q ? atce_pkg::EX_IDLE : atce_pkg::EX_DONE;
			end
			atce_pkg::EX_READ: begin
				cell_d = bound_q ? rdata_q : 16'h0000;
				state_d = atce_pkg::EX_DONE;
			end
			atce_pkg::EX_DONE: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = atce_pkg::EX_IDLE;
			end
			default: state_d = atce_pkg::EX_IDLE;
		endcase
	end

	assign cell_value = cell_q;
	assign cursor_column = col_q;
	assign cursor_row = row_q;
	assign text_attribute = attr_q;

	always_ff @(posedge clk) begin
		if (cur_load) cur_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= atce_pkg::EX_IDLE;
			col_q <= '0;
			row_q <= '0;
			attr_q <= atce_pkg::ResetAttribute;
			dflt_q <= atce_pkg::ResetAttribute;
			rep_q <= '0;
			esc_q <= 1'b0;
			ptr_q <= '0;
			bound_q <= 1'b0;
			cell_q <= '0;
			init_q <= 1'b1;
		end else begin
			state_q <= state_d;
			col_q <= col_d;
			row_q <= row_d;
			attr_q <= attr_d;
			rep_q <= rep_d;
			esc_q <= esc_d;
			ptr_q <= ptr_d;
			bound_q <= bound_d;
			cell_q <= cell_d;
			if (state_q == atce_pkg::EX_FILL && ptr_q == PtrW'(Last)) init_q <= 1'b0;
			if (cfg_valid) dflt_q <= cfg_data;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
			col_q < atce_pkg::ColW'(atce_pkg::Columns) && row_q < atce_pkg::RowW'(atce_pkg::Rows))
		else $error("cursor out of screen");
	assert property (@(posedge clk) disable iff (!arst_n) init_q |-> !out_valid)
		else $error("result during clearing pass");
	assert property (@(posedge clk) disable iff (!arst_n)
			(out_valid && out_stall) |=> out_valid && $stable(cell_q))
		else $error("result dropped while stalled");

endmodule

FILE: rtl/ansi_text_console_engine.sv
// A read goes through the queue and the executor states WORK, READ and DONE; any other
// byte through WORK and DONE, with one write per tab space and one for a printed ESC.
// A scroll reads and writes each copied cell and writes each blanked cell; a clear
// writes every cell. After reset a clearing pass zeroes the store before the first
// result; the queue still takes two requests.
// The executor handles one request at a time.
// ----------------------------------------------------------------------------
// ansi_text_console_engine: 80x25 text console with ANSI escape parsing
// Parser front end, command queue and executor with the cell store.
// ----------------------------------------------------------------------------
module ansi_text_console_engine (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [7:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic req_type,
	input logic [7:0] char_byte,
	input logic [atce_pkg::AddrW-1:0] read_address,
	output logic out_valid,
	input logic out_stall,
	output logic [15:0] cell_value,
	output logic [atce_pkg::ColW-1:0] cursor_column,
	output logic [atce_pkg::RowW-1:0] cursor_row,
	output logic [7:0] text_attribute
);

	atce_pkg::cmd_t fcmd, qcmd;
	logic fvalid, fstall, qvalid, qtake;

	atce_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .req_type, .char_byte, .read_address,
		.cmd_valid(fvalid), .cmd_stall(fstall), .cmd(fcmd)
	);

	atce_queue u_queue (
		.clk, .arst_n, .wr_valid(fvalid), .wr_stall(fstall), .wr_data(fcmd),
		.rd_valid(qvalid), .rd_take(qtake), .rd_data(qcmd)
	);

	atce_back u_back (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_data,
		.cmd_valid(qvalid), .cmd_take(qtake), .cmd(qcmd),
		.out_valid, .out_stall, .cell_value, .cursor_column, .cursor_row, .text_attribute
	);

endmodule
